// ----- design/pixel_area_weighted_grid_splat_unit_macros.svh -----
// Assertion macros for the grid splat unit
`ifndef PIXEL_AREA_WEIGHTED_GRID_SPLAT_UNIT_MACROS_SVH
`define PIXEL_AREA_WEIGHTED_GRID_SPLAT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while arst_n is low
`define PAWGS_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pawgs: check failed");
// next-cycle implication
`define PAWGS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pawgs: check failed");
`else
`define PAWGS_ASSERT_SAME(label, ante, cons)
`define PAWGS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- design/pawgs_pkg.sv -----
// Types, constants and helper functions shared by the grid splat unit
package pawgs_pkg;

	localparam int COORD_W    = 24;
	localparam int FRAC_BITS  = 12;
	localparam int STEP_W     = 14;
	localparam int STRIDE_W   = 12;
	localparam int VALUE_W    = 24;
	localparam int ADDEND_W   = 36;
	localparam int RS_W       = 16;
	localparam int EXT_W      = 17;
	localparam int SPAN_W     = 25;
	localparam int CELL_W     = SPAN_W - FRAC_BITS;
	localparam int WEIGHT_W   = FRAC_BITS + 1;
	localparam int MAX_CELLS  = 8;
	localparam int CNT_W      = 3;
	localparam int N_W        = 4;
	localparam int MUL_A_W    = 25;
	localparam int MUL_B_W    = 14;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int IN_TDATA_W = ((VALUE_W + 7) / 8) * 8;

	localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1 << FRAC_BITS);

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_ORIGIN_X   = 3'd0;
	localparam cfg_idx_t REG_ORIGIN_Y   = 3'd1;
	localparam cfg_idx_t REG_COL_STEP_X = 3'd2;
	localparam cfg_idx_t REG_COL_STEP_Y = 3'd3;
	localparam cfg_idx_t REG_ROW_STEP_X = 3'd4;
	localparam cfg_idx_t REG_ROW_STEP_Y = 3'd5;
	localparam cfg_idx_t REG_STRIDE     = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP_A,
		ST_SETUP_B,
		ST_AREA,
		ST_VALUE,
		ST_INDEX,
		ST_PUSH
	} state_t;

	typedef logic signed [MUL_A_W-1:0] mul_a_t;
	typedef logic signed [MUL_B_W-1:0] mul_b_t;
	typedef logic signed [MUL_P_W-1:0] mul_p_t;

	// long rows step 2.5x: floor(5*rs/2)
	function automatic logic signed [RS_W-1:0] row_step_eff(
		input logic signed [STEP_W-1:0] rs,
		input logic                     is_long
	);
		logic signed [RS_W:0] five;
		five = (RS_W+1)'(rs) + ((RS_W+1)'(rs) <<< 2);
		if (is_long) begin
			return five[RS_W:1];
		end else begin
			return RS_W'(rs);
		end
	endfunction

	// per-axis overlap of cell i out of n covered cells, Q.12
	function automatic logic [WEIGHT_W-1:0] axis_weight(
		input logic [SPAN_W-1:0] lo,
		input logic [SPAN_W-1:0] hi,
		input logic [CNT_W-1:0]  i,
		input logic [N_W-1:0]    n
	);
		logic [SPAN_W-1:0] d;
		d = hi - lo;
		if (n == N_W'(1)) begin
			return d[WEIGHT_W-1:0];
		end else if (i == '0) begin
			return WEIGHT_ONE - {1'b0, lo[FRAC_BITS-1:0]};
		end else if ({1'b0, i} == n - N_W'(1)) begin
			return {1'b0, hi[FRAC_BITS-1:0]};
		end else begin
			return WEIGHT_ONE;
		end
	endfunction

endpackage

// ----- design/pawgs_mul.sv -----
// Shared registered signed multiplier for area, addend and the row base of the cell index
module pawgs_mul (
	input  logic              clk,
	input  pawgs_pkg::mul_a_t a,
	input  pawgs_pkg::mul_b_t b,
	output pawgs_pkg::mul_p_t p
);
	import pawgs_pkg::*;

	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule

// ----- design/pixel_area_weighted_grid_splat_unit.sv -----
// Grid splat unit: one input beat per pixel, one result beat for each of up to eight cells.
// After SETUP_A and SETUP_B, each cell goes through AREA, VALUE, INDEX and PUSH, as the
// one multiplier does area, value and row base; PUSH registers each beat unless stalled.
// Input is taken only in idle; the output register lets the next pixel start meanwhile.
// arst_n low clears the walk to column 0 row 0 at origin 0 and loads register defaults.
`include "pixel_area_weighted_grid_splat_unit_macros.svh"
module pixel_area_weighted_grid_splat_unit #(
	parameter int SECTION_COLUMNS = 185,
	parameter int SECTION_ROWS    = 388,
	parameter int GRID_INDEX_BITS = 22
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    wr_en,
	input  logic [pawgs_pkg::CFG_IDX_W-1:0]         wr_index,
	input  logic [pawgs_pkg::CFG_DATA_W-1:0]        wr_data,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [pawgs_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // pixel_value
	input  logic                                    s_axis_tuser,  // start_of_section
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	// cell_index, addend, zero fill
	output logic [((GRID_INDEX_BITS + pawgs_pkg::ADDEND_W + 7) / 8) * 8 - 1:0] m_axis_tdata,
	output logic                                    m_axis_tuser,  // in_grid
	output logic                                    m_axis_tlast
);
	import pawgs_pkg::*;

	localparam int COL_W   = $clog2(SECTION_COLUMNS + 1);
	localparam int ROW_W   = $clog2(SECTION_ROWS + 1);
	localparam int IDX_W   = (GRID_INDEX_BITS > SPAN_W) ? GRID_INDEX_BITS : SPAN_W;
	localparam int TDATA_W = ((GRID_INDEX_BITS + ADDEND_W + 7) / 8) * 8;
	localparam logic [COL_W-1:0] COL_LAST   = COL_W'(SECTION_COLUMNS - 1);
	localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(SECTION_ROWS - 1);
	localparam logic [ROW_W-1:0] LONG_ROW_A = ROW_W'(SECTION_ROWS / 2 - 1);
	localparam logic [ROW_W-1:0] LONG_ROW_B = ROW_W'(SECTION_ROWS / 2);

	// configuration
	logic signed [COORD_W-1:0] origin_x_q, origin_y_q;
	logic signed [STEP_W-1:0]  col_step_x_q, col_step_y_q, row_step_x_q, row_step_y_q;
	logic [STRIDE_W-1:0]       stride_q;

	// walk state
	logic [COL_W-1:0]          col_q;
	logic [ROW_W-1:0]          row_q;
	logic signed [COORD_W-1:0] col_start_x_q, col_start_y_q, corner_x_q, corner_y_q;

	// per-pixel work registers
	state_t                    state_q, state_d;
	logic signed [VALUE_W-1:0] value_q;
	logic signed [COORD_W-1:0] cx_q, cy_q;
	logic signed [EXT_W-1:0]   ext_x_q, ext_y_q;
	logic signed [SPAN_W-1:0]  lo_x_q, hi_x_q, lo_y_q, hi_y_q;
	logic [CNT_W-1:0]          ix_q, iy_q, cnt_q;
	logic signed [ADDEND_W-1:0] addend_q;

	// output register
	logic                       out_valid_q;
	logic [GRID_INDEX_BITS-1:0] out_index_q;
	logic [ADDEND_W-1:0]        out_addend_q;
	logic                       out_in_grid_q, out_last_q;

	logic                      is_long;
	logic signed [RS_W-1:0]    rs_x, rs_y;
	logic signed [EXT_W-1:0]   ext_x, ext_y;
	logic signed [SPAN_W-1:0]  sum_x, sum_y;
	logic signed [CELL_W-1:0]  g0_x, g1_x, g0_y, g1_y, gx, gy;
	logic [N_W-1:0]            nx_x, ny;
	logic [WEIGHT_W-1:0]       wx, wy, area;
	logic [IDX_W-1:0]          idx;
	logic                      on_grid, last_c, push_fire, in_fire;
	mul_a_t                    mul_a;
	mul_b_t                    mul_b;
	mul_p_t                    prod;

	pawgs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q   <= '0;
			origin_y_q   <= '0;
			col_step_x_q <= STEP_W'(4096);
			col_step_y_q <= '0;
			row_step_x_q <= '0;
			row_step_y_q <= STEP_W'(4096);
			stride_q     <= STRIDE_W'(2048);
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ORIGIN_X:   origin_x_q   <= wr_data[COORD_W-1:0];
				REG_ORIGIN_Y:   origin_y_q   <= wr_data[COORD_W-1:0];
				REG_COL_STEP_X: col_step_x_q <= wr_data[STEP_W-1:0];
				REG_COL_STEP_Y: col_step_y_q <= wr_data[STEP_W-1:0];
				REG_ROW_STEP_X: row_step_x_q <= wr_data[STEP_W-1:0];
				REG_ROW_STEP_Y: row_step_y_q <= wr_data[STEP_W-1:0];
				REG_STRIDE:     stride_q     <= wr_data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	// setup arithmetic
	assign is_long = (row_q == LONG_ROW_A) || (row_q == LONG_ROW_B);
	assign rs_x    = row_step_eff(row_step_x_q, is_long);
	assign rs_y    = row_step_eff(row_step_y_q, is_long);
	assign ext_x   = EXT_W'(col_step_x_q) + EXT_W'(rs_x);
	assign ext_y   = EXT_W'(col_step_y_q) + EXT_W'(rs_y);
	assign sum_x   = SPAN_W'(cx_q) + SPAN_W'(ext_x_q);
	assign sum_y   = SPAN_W'(cy_q) + SPAN_W'(ext_y_q);

	// cell scan arithmetic
	assign g0_x = lo_x_q[SPAN_W-1:FRAC_BITS];
	assign g1_x = hi_x_q[SPAN_W-1:FRAC_BITS];
	assign g0_y = lo_y_q[SPAN_W-1:FRAC_BITS];
	assign g1_y = hi_y_q[SPAN_W-1:FRAC_BITS];
	assign nx_x = N_W'(g1_x - g0_x) + N_W'(1);
	assign ny   = N_W'(g1_y - g0_y) + N_W'(1);
	assign gx   = g0_x + CELL_W'(ix_q);
	assign gy   = g0_y + CELL_W'(iy_q);
	assign wx   = axis_weight(lo_x_q, hi_x_q, ix_q, nx_x);
	assign wy   = axis_weight(lo_y_q, hi_y_q, iy_q, ny);
	assign area = prod[FRAC_BITS+WEIGHT_W-1:FRAC_BITS];

	// in ST_PUSH the product holds gy * stride
	assign idx     = IDX_W'(prod) + IDX_W'(gx);
	assign on_grid = !gx[CELL_W-1] && !gy[CELL_W-1] && (gx[STRIDE_W-1:0] < stride_q) &&
			((idx >> GRID_INDEX_BITS) == '0);
	// pixels covering more than eight cells are cut after the eighth
	assign last_c = (cnt_q == CNT_W'(MAX_CELLS - 1)) ||
			(({1'b0, ix_q} == nx_x - N_W'(1)) && ({1'b0, iy_q} == ny - N_W'(1)));

	assign in_fire = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		push_fire     = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_SETUP_A;
				end
			end
			ST_SETUP_A: state_d = ST_SETUP_B;
			ST_SETUP_B: state_d = ST_AREA;
			ST_AREA: begin
				mul_a   = MUL_A_W'(wx);
				mul_b   = MUL_B_W'(wy);
				state_d = ST_VALUE;
			end
			ST_VALUE: begin
				mul_a   = MUL_A_W'(value_q);
				mul_b   = MUL_B_W'(area);
				state_d = ST_INDEX;
			end
			ST_INDEX: begin
				mul_a   = MUL_A_W'(gy);
				mul_b   = MUL_B_W'(stride_q);
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				// keep the row base in the product while the output stalls
				mul_a = MUL_A_W'(gy);
				mul_b = MUL_B_W'(stride_q);
				if (!out_valid_q || m_axis_tready) begin
					push_fire = 1'b1;
					state_d   = last_c ? ST_IDLE : ST_AREA;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// walk and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q         <= '0;
			row_q         <= '0;
			col_start_x_q <= '0;
			col_start_y_q <= '0;
			corner_x_q    <= '0;
			corner_y_q    <= '0;
			ix_q          <= '0;
			iy_q          <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (in_fire && s_axis_tuser) begin
				col_q         <= '0;
				row_q         <= '0;
				col_start_x_q <= origin_x_q;
				col_start_y_q <= origin_y_q;
				corner_x_q    <= origin_x_q;
				corner_y_q    <= origin_y_q;
			end
			if (state_q == ST_SETUP_A) begin
				if (row_q == ROW_LAST) begin
					row_q <= '0;
					if (col_q == COL_LAST) begin
						col_q         <= '0;
						col_start_x_q <= origin_x_q;
						col_start_y_q <= origin_y_q;
						corner_x_q    <= origin_x_q;
						corner_y_q    <= origin_y_q;
					end else begin
						col_q         <= col_q + COL_W'(1);
						col_start_x_q <= col_start_x_q + COORD_W'(col_step_x_q);
						col_start_y_q <= col_start_y_q + COORD_W'(col_step_y_q);
						corner_x_q    <= col_start_x_q + COORD_W'(col_step_x_q);
						corner_y_q    <= col_start_y_q + COORD_W'(col_step_y_q);
					end
				end else begin
					row_q      <= row_q + ROW_W'(1);
					corner_x_q <= corner_x_q + COORD_W'(rs_x);
					corner_y_q <= corner_y_q + COORD_W'(rs_y);
				end
			end
			if (state_q == ST_SETUP_B) begin
				ix_q  <= '0;
				iy_q  <= '0;
				cnt_q <= '0;
			end
			if (push_fire) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if ({1'b0, ix_q} == nx_x - N_W'(1)) begin
					ix_q <= '0;
					iy_q <= iy_q + CNT_W'(1);
				end else begin
					ix_q <= ix_q + CNT_W'(1);
				end
			end
			if (push_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_q <= s_axis_tdata[VALUE_W-1:0];
		end
		if (state_q == ST_SETUP_A) begin
			cx_q    <= corner_x_q;
			cy_q    <= corner_y_q;
			ext_x_q <= ext_x;
			ext_y_q <= ext_y;
		end
		if (state_q == ST_SETUP_B) begin
			if (sum_x < SPAN_W'(cx_q)) begin
				lo_x_q <= sum_x;
				hi_x_q <= SPAN_W'(cx_q);
			end else begin
				lo_x_q <= SPAN_W'(cx_q);
				hi_x_q <= sum_x;
			end
			if (sum_y < SPAN_W'(cy_q)) begin
				lo_y_q <= sum_y;
				hi_y_q <= SPAN_W'(cy_q);
			end else begin
				lo_y_q <= SPAN_W'(cy_q);
				hi_y_q <= sum_y;
			end
		end
		if (state_q == ST_INDEX) begin
			addend_q <= prod[ADDEND_W-1:0];
		end
		if (push_fire) begin
			out_index_q   <= on_grid ? idx[GRID_INDEX_BITS-1:0] : '0;
			out_addend_q  <= addend_q;
			out_in_grid_q <= on_grid;
			out_last_q    <= last_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'({out_addend_q, out_index_q});
	assign m_axis_tuser  = out_in_grid_q;
	assign m_axis_tlast  = out_last_q;

	`PAWGS_ASSERT_NEXT(a_accept_setup, in_fire, state_q == ST_SETUP_A)
	`PAWGS_ASSERT_SAME(a_span_cells, state_q == ST_AREA, nx_x != '0 && nx_x <= N_W'(MAX_CELLS) && ny != '0 && ny <= N_W'(MAX_CELLS))
	`PAWGS_ASSERT_NEXT(a_last_idle, push_fire && last_c, state_q == ST_IDLE && m_axis_tvalid && m_axis_tlast)
	`PAWGS_ASSERT_SAME(a_walk_range, 1'b1, row_q <= ROW_LAST && col_q <= COL_LAST)

endmodule
